// ----- sv/dqfa_pkg.sv -----
// dqfa_pkg: shared types, constants and microcode table of the fixed-answer dns responder
// no dependencies; imported by every module of the block
`default_nettype none

package dqfa_pkg;

  localparam int MAX_PACKET_BYTES = 256;
  localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
  localparam int RLEN_W           = $clog2(MAX_PACKET_BYTES + 2);
  localparam int HDR_BYTES        = 12;
  localparam int HDR_IDX_W        = $clog2(HDR_BYTES);
  localparam int TC_BYTES         = 4;
  localparam int TC_IDX_W         = $clog2(TC_BYTES);
  localparam int ANSWER_BYTES     = 16;

  localparam logic [31:0] ADDRESS_RESET = 32'hC0A8_0401;
  localparam logic [31:0] TTL_RESET     = 32'd60;
  localparam logic [15:0] FLAGS_RESET   = 16'h8180;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;
  localparam logic [7:0] PTR_HI    = 8'hC0;
  localparam logic [7:0] PTR_LO    = 8'h0C;
  localparam logic [7:0] RDLEN_LO  = 8'h04;

  // configuration register indexes
  localparam logic [1:0] CFG_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_TTL     = 2'd1;
  localparam logic [1:0] CFG_FLAGS   = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_NAME,
    PH_TYPECLASS,
    PH_DROP
  } phase_t;

  typedef enum logic {
    OP_EMIT,
    OP_DONE
  } op_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_HDR,
    COND_NAME,
    COND_TC,
    COND_ZERO,
    COND_ANSW
  } cond_t;

  typedef enum logic [2:0] {
    SRC_CONST,
    SRC_HDR,
    SRC_FLAGS_HI,
    SRC_FLAGS_LO,
    SRC_IN,
    SRC_TC,
    SRC_TTL,
    SRC_ADDR
  } src_t;

  // program layout
  localparam int UCODE_LEN = 35;
  localparam int UPC_W     = $clog2(UCODE_LEN);
  localparam int UA_NAME   = 12;
  localparam int UA_TC     = 13;
  localparam int UA_ZERO   = 17;
  localparam int UA_ANSW   = 18;
  localparam int UA_DONE   = 34;

  typedef struct packed {
    op_t                  op;
    cond_t                cond;
    src_t                 src;
    logic [HDR_IDX_W-1:0] idx;
    logic [7:0]           konst;
    logic [UPC_W-1:0]     target;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    logic                 emit;
    logic                 done;
    src_t                 src;
    logic [HDR_IDX_W-1:0] idx;
    logic [7:0]           konst;
  } ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic hdr;
    logic name;
    logic tc;
    logic zero;
    logic answ;
    logic adv_ok;
  } stat_t;

  typedef struct packed {
    logic [7:0] query_byte;
    logic       packet_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       run_last;
    logic       reply_end;
  } out_word_t;

  function automatic ucode_t uc(op_t op, cond_t cond, src_t src, int idx,
                                logic [7:0] konst, int target);
    ucode_t w;
    w.op     = op;
    w.cond   = cond;
    w.src    = src;
    w.idx    = HDR_IDX_W'(idx);
    w.konst  = konst;
    w.target = UPC_W'(target);
    return w;
  endfunction

  // most significant byte first
  function automatic logic [7:0] byte_of(logic [31:0] w, logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = w[31:24];
      2'd1:    b = w[23:16];
      2'd2:    b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

  // each group starts with a conditional emit that jumps past the group when false
  function automatic ucode_t ucode_rom(logic [UPC_W-1:0] addr);
    ucode_t w;
    case (int'(addr))
      0:  w = uc(OP_EMIT, COND_HDR,    SRC_HDR,      0, BYTE_ZERO, UA_NAME);
      1:  w = uc(OP_EMIT, COND_ALWAYS, SRC_HDR,      1, BYTE_ZERO, 0);
      2:  w = uc(OP_EMIT, COND_ALWAYS, SRC_FLAGS_HI, 0, BYTE_ZERO, 0);
      3:  w = uc(OP_EMIT, COND_ALWAYS, SRC_FLAGS_LO, 0, BYTE_ZERO, 0);
      4:  w = uc(OP_EMIT, COND_ALWAYS, SRC_HDR,      4, BYTE_ZERO, 0);
      5:  w = uc(OP_EMIT, COND_ALWAYS, SRC_HDR,      5, BYTE_ZERO, 0);
      6:  w = uc(OP_EMIT, COND_ALWAYS, SRC_CONST,    0, BYTE_ZERO, 0);
      7:  w = uc(OP_EMIT, COND_ALWAYS, SRC_CONST,    0, BYTE_ONE,  0);
      8:  w = uc(OP_EMIT, COND_ALWAYS, SRC_HDR,      8, BYTE_ZERO, 0);
      9:  w = uc(OP_EMIT, COND_ALWAYS, SRC_HDR,      9, BYTE_ZERO, 0);
      10: w = uc(OP_EMIT, COND_ALWAYS, SRC_HDR,     10, BYTE_ZERO, 0);
      11: w = uc(OP_EMIT, COND_ALWAYS, SRC_HDR,     11, BYTE_ZERO, 0);
      12: w = uc(OP_EMIT, COND_NAME,   SRC_IN,       0, BYTE_ZERO, UA_TC);
      13: w = uc(OP_EMIT, COND_TC,     SRC_TC,       0, BYTE_ZERO, UA_ZERO);
      14: w = uc(OP_EMIT, COND_ALWAYS, SRC_TC,       1, BYTE_ZERO, 0);
      15: w = uc(OP_EMIT, COND_ALWAYS, SRC_TC,       2, BYTE_ZERO, 0);
      16: w = uc(OP_EMIT, COND_ALWAYS, SRC_TC,       3, BYTE_ZERO, 0);
      17: w = uc(OP_EMIT, COND_ZERO,   SRC_CONST,    0, BYTE_ZERO, UA_ANSW);
      18: w = uc(OP_EMIT, COND_ANSW,   SRC_CONST,    0, PTR_HI,    UA_DONE);
      19: w = uc(OP_EMIT, COND_ALWAYS, SRC_CONST,    0, PTR_LO,    0);
      20: w = uc(OP_EMIT, COND_ALWAYS, SRC_CONST,    0, BYTE_ZERO, 0);
      21: w = uc(OP_EMIT, COND_ALWAYS, SRC_CONST,    0, BYTE_ONE,  0);
      22: w = uc(OP_EMIT, COND_ALWAYS, SRC_CONST,    0, BYTE_ZERO, 0);
      23: w = uc(OP_EMIT, COND_ALWAYS, SRC_CONST,    0, BYTE_ONE,  0);
      24: w = uc(OP_EMIT, COND_ALWAYS, SRC_TTL,      0, BYTE_ZERO, 0);
      25: w = uc(OP_EMIT, COND_ALWAYS, SRC_TTL,      1, BYTE_ZERO, 0);
      26: w = uc(OP_EMIT, COND_ALWAYS, SRC_TTL,      2, BYTE_ZERO, 0);
      27: w = uc(OP_EMIT, COND_ALWAYS, SRC_TTL,      3, BYTE_ZERO, 0);
      28: w = uc(OP_EMIT, COND_ALWAYS, SRC_CONST,    0, BYTE_ZERO, 0);
      29: w = uc(OP_EMIT, COND_ALWAYS, SRC_CONST,    0, RDLEN_LO,  0);
      30: w = uc(OP_EMIT, COND_ALWAYS, SRC_ADDR,     0, BYTE_ZERO, 0);
      31: w = uc(OP_EMIT, COND_ALWAYS, SRC_ADDR,     1, BYTE_ZERO, 0);
      32: w = uc(OP_EMIT, COND_ALWAYS, SRC_ADDR,     2, BYTE_ZERO, 0);
      33: w = uc(OP_EMIT, COND_ALWAYS, SRC_ADDR,     3, BYTE_ZERO, 0);
      default: w = uc(OP_DONE, COND_ALWAYS, SRC_CONST, 0, BYTE_ZERO, 0);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- sv/dqfa_seq.sv -----
// dqfa_seq: microcode sequencer, step counter plus conditional jumps over the program table
// depends on dqfa_pkg (ucode_rom, ctl_t, stat_t)
`default_nettype none

module dqfa_seq (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             start,
  input  dqfa_pkg::stat_t stat,
  output dqfa_pkg::ctl_t  ctl,
  output logic            busy
);
  import dqfa_pkg::*;

  logic             busy_r, busy_nxt;
  logic [UPC_W-1:0] upc_r, upc_nxt;
  ucode_t           word;
  logic             cond_ok;

  assign word = ucode_rom(upc_r);
  assign busy = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
    end
  end

  always_comb begin
    case (word.cond)
      COND_ALWAYS: cond_ok = 1'b1;
      COND_HDR:    cond_ok = stat.hdr;
      COND_NAME:   cond_ok = stat.name;
      COND_TC:     cond_ok = stat.tc;
      COND_ZERO:   cond_ok = stat.zero;
      COND_ANSW:   cond_ok = stat.answ;
      default:     cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    busy_nxt  = busy_r;
    upc_nxt   = upc_r;
    ctl       = '0;
    ctl.src   = word.src;
    ctl.idx   = word.idx;
    ctl.konst = word.konst;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        upc_nxt  = '0;
      end
    end else begin
      case (word.op)
        OP_EMIT: begin
          if (!cond_ok) begin
            upc_nxt = word.target;
          end else if (stat.adv_ok) begin
            ctl.emit = 1'b1;
            upc_nxt  = upc_r + 1'b1;
          end
        end
        OP_DONE: begin
          if (stat.adv_ok) begin
            ctl.done = 1'b1;
            busy_nxt = 1'b0;
            upc_nxt  = '0;
          end
        end
        default: begin
          busy_nxt = 1'b0;
          upc_nxt  = '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/dqfa_dp.sv -----
// dqfa_dp: datapath with config registers, packet state, header and type/class buffers,
// byte select, one-word hold stage and output register; depends on dqfa_pkg
`default_nettype none

module dqfa_dp (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   accept,
  input  dqfa_pkg::in_word_t    in_data,
  input  dqfa_pkg::ctl_t        ctl,
  output dqfa_pkg::stat_t       stat,
  output logic                  out_valid,
  input  wire                   out_stall,
  output dqfa_pkg::out_word_t   out_data,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [1:0]            cfg_index,
  input  wire  [31:0]           cfg_data
);
  import dqfa_pkg::*;

  localparam int SUM_W = RLEN_W + 1;

  logic [31:0] address_r, ttl_r;
  logic [15:0] flags_r;

  logic [POS_W-1:0]    pos_r, pos_nxt;
  phase_t              phase_r, phase_nxt, phase_new;
  logic [TC_IDX_W-1:0] tc_cnt_r, tc_cnt_nxt;
  logic [RLEN_W-1:0]   rlen_r, rlen_nxt;
  logic [SUM_W-1:0]    rlen_sum;

  logic [7:0] hdr_mem [HDR_BYTES];
  logic [7:0] tc_mem  [TC_BYTES];
  logic [7:0] in_byte_r;

  logic f_hdr_r, f_name_r, f_tc_r, f_zero_r, f_endok_r, f_end_r;
  logic f_hdr_nxt, f_name_nxt, f_tc_nxt, f_zero_nxt, f_endok_nxt;

  logic in_range, name_open, hdr_we, tc_we;
  logic [7:0] emit_byte;

  logic       pend_valid_r, pend_valid_nxt;
  logic [7:0] pend_byte_r;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_data_r;
  logic       can_load, push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      address_r <= ADDRESS_RESET;
      ttl_r     <= TTL_RESET;
      flags_r   <= FLAGS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ADDRESS: address_r <= cfg_data;
        CFG_TTL:     ttl_r     <= cfg_data;
        CFG_FLAGS:   flags_r   <= cfg_data[15:0];
        default:     ;
      endcase
    end
  end

  // per-word decode, taken at accept
  always_comb begin
    in_range  = pos_r < POS_W'(MAX_PACKET_BYTES);
    hdr_we    = accept && in_range && (phase_r == PH_HEADER);
    tc_we     = accept && in_range && (phase_r == PH_TYPECLASS);
    f_hdr_nxt = in_range && (phase_r == PH_HEADER) && (pos_r == POS_W'(HDR_BYTES - 1));
    f_name_nxt = in_range && (phase_r == PH_NAME);
    f_tc_nxt  = in_range && (phase_r == PH_TYPECLASS) && (tc_cnt_r == TC_IDX_W'(TC_BYTES - 1));
    // past the size limit a name still counts as open
    name_open = f_hdr_nxt || (f_name_nxt && (in_data.query_byte != BYTE_ZERO)) ||
                (!in_range && (phase_r == PH_NAME));

    phase_new = phase_r;
    if (f_hdr_nxt) begin
      phase_new = PH_NAME;
    end else if (f_name_nxt && (in_data.query_byte == BYTE_ZERO)) begin
      phase_new = PH_TYPECLASS;
    end else if (f_tc_nxt) begin
      phase_new = PH_DROP;
    end

    f_endok_nxt = in_data.packet_end && (phase_new != PH_HEADER);
    f_zero_nxt  = f_endok_nxt && name_open && (phase_new == PH_NAME);

    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    tc_cnt_nxt = tc_cnt_r;
    if (accept) begin
      if (in_data.packet_end) begin
        pos_nxt    = '0;
        phase_nxt  = PH_HEADER;
        tc_cnt_nxt = '0;
      end else begin
        pos_nxt   = in_range ? pos_r + 1'b1 : pos_r;
        phase_nxt = phase_new;
        if (tc_we) begin
          tc_cnt_nxt = tc_cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      phase_r   <= PH_HEADER;
      tc_cnt_r  <= '0;
      f_hdr_r   <= 1'b0;
      f_name_r  <= 1'b0;
      f_tc_r    <= 1'b0;
      f_zero_r  <= 1'b0;
      f_endok_r <= 1'b0;
      f_end_r   <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      phase_r  <= phase_nxt;
      tc_cnt_r <= tc_cnt_nxt;
      if (accept) begin
        f_hdr_r   <= f_hdr_nxt;
        f_name_r  <= f_name_nxt;
        f_tc_r    <= f_tc_nxt;
        f_zero_r  <= f_zero_nxt;
        f_endok_r <= f_endok_nxt;
        f_end_r   <= in_data.packet_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_data.query_byte;
    end
    if (hdr_we) begin
      hdr_mem[pos_r[HDR_IDX_W-1:0]] <= in_data.query_byte;
    end
    if (tc_we) begin
      tc_mem[tc_cnt_r] <= in_data.query_byte;
    end
  end

  always_comb begin
    case (ctl.src)
      SRC_CONST:    emit_byte = ctl.konst;
      SRC_HDR:      emit_byte = hdr_mem[ctl.idx];
      SRC_FLAGS_HI: emit_byte = flags_r[15:8];
      SRC_FLAGS_LO: emit_byte = flags_r[7:0];
      SRC_IN:       emit_byte = in_byte_r;
      SRC_TC:       emit_byte = tc_mem[ctl.idx[TC_IDX_W-1:0]];
      SRC_TTL:      emit_byte = byte_of(ttl_r, ctl.idx[1:0]);
      SRC_ADDR:     emit_byte = byte_of(address_r, ctl.idx[1:0]);
      default:      emit_byte = BYTE_ZERO;
    endcase
  end

  // running response length, checked before the answer is appended
  always_comb begin
    rlen_nxt = rlen_r;
    if (ctl.emit) begin
      rlen_nxt = rlen_r + 1'b1;
    end else if (ctl.done && f_end_r) begin
      rlen_nxt = '0;
    end
    rlen_sum = SUM_W'(rlen_r) + SUM_W'(ANSWER_BYTES);
  end

  // hold one word back so the last of a run can be flagged at done
  always_comb begin
    can_load       = !out_valid_r || !out_stall;
    push           = (ctl.emit || ctl.done) && pend_valid_r;
    out_valid_nxt  = push || (out_valid_r && out_stall);
    pend_valid_nxt = pend_valid_r;
    if (ctl.emit) begin
      pend_valid_nxt = 1'b1;
    end else if (ctl.done) begin
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rlen_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rlen_r       <= rlen_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      pend_byte_r <= emit_byte;
    end
    if (push) begin
      out_data_r.reply_byte <= pend_byte_r;
      out_data_r.run_last   <= ctl.done;
      out_data_r.reply_end  <= ctl.done && f_end_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign stat.hdr    = f_hdr_r;
  assign stat.name   = f_name_r;
  assign stat.tc     = f_tc_r;
  assign stat.zero   = f_zero_r;
  assign stat.answ   = f_endok_r && (rlen_sum <= SUM_W'(MAX_PACKET_BYTES));
  assign stat.adv_ok = !pend_valid_r || can_load;

endmodule

`default_nettype wire

// ----- sv/dns_query_to_fixed_answer.sv -----
// a query byte is taken, then the sequencer walks the program one step per cycle unless
// output stall holds it; a new query byte is stalled until the walk for the last one is
// done, and the last word of a run is loaded into the output register at done
// reset: synchronous active-low rst_n clears packet state, counters, sequencer and
// output valid and reloads the config registers; buffers are not cleared
`default_nettype none

module dns_query_to_fixed_answer (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  dqfa_pkg::in_word_t    in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output dqfa_pkg::out_word_t   out_data,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [1:0]            cfg_index,
  input  wire  [31:0]           cfg_data
);
  import dqfa_pkg::*;

  logic  busy;
  logic  accept;
  ctl_t  ctl;
  stat_t stat;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  dqfa_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  dqfa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .ctl       (ctl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

// ----- sv/dqfa_checker.sv -----
// dqfa_checker: port-level assertions for the fixed-answer dns responder, bound to the top
// depends on dqfa_pkg and dns_query_to_fixed_answer
`default_nettype none

module dqfa_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_stall,
  input dqfa_pkg::in_word_t  in_data,
  input wire                 out_valid,
  input wire                 out_stall,
  input dqfa_pkg::out_word_t out_data
);
  import dqfa_pkg::*;

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // offered query word holds while the block stalls it
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input word changed while stalled");

  // end of response is always the last word of its run
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reply_end |-> out_data.run_last)
    else $error("reply_end without run_last");

  // one byte in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again without processing");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind dns_query_to_fixed_answer dqfa_checker u_dqfa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
